>>> rtl/core/zcoc_pkg.sv
// ----------------------------------------------------------------------------
// Zone crossing occupancy counter package
// Shared types, register indexes, event codes and the window test.
// ----------------------------------------------------------------------------
package zcoc_pkg;

   localparam int unsigned DIST_W  = 18;
   localparam int unsigned ANGLE_W = 16;
   localparam int unsigned QUAL_W  = 8;
   localparam int unsigned AGE_W   = 8;
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 18;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_ANGLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_ANGLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LIMIT = 3'd5;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_COUNTED = 2'd1;
   localparam logic [1:0] EV_TEACHER = 2'd2;

   typedef struct packed {
      logic [DIST_W-1:0]  range_limit;
      logic [ANGLE_W-1:0] entry_angle;
      logic [ANGLE_W-1:0] exit_angle;
      logic [ANGLE_W-1:0] half_width;
      logic [AGE_W-1:0]   cooldown;
      logic [COUNT_W-1:0] count_limit;
   } csr_type;

   typedef struct packed {
      logic [1:0] ev_code;
      logic       counted;
   } zone_status_type;

   function automatic logic in_window(logic [ANGLE_W-1:0] angle,
                                      logic [ANGLE_W-1:0] line,
                                      logic [ANGLE_W-1:0] window);
      logic [ANGLE_W-1:0] diff;
      diff = (angle >= line) ? (angle - line) : (line - angle);
      return diff < window;
   endfunction

endpackage

>>> rtl/core/zcoc_csr.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file with the documented reset values.
// ----------------------------------------------------------------------------
module zcoc_csr
   import zcoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output csr_type               cfg
);

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RANGE_LIMIT: cfg_in.range_limit = csr_data[DIST_W-1:0];
            CSR_ENTRY_ANGLE: cfg_in.entry_angle = csr_data[ANGLE_W-1:0];
            CSR_EXIT_ANGLE:  cfg_in.exit_angle  = csr_data[ANGLE_W-1:0];
            CSR_HALF_WIDTH:  cfg_in.half_width  = csr_data[ANGLE_W-1:0];
            CSR_COOLDOWN:    cfg_in.cooldown    = csr_data[AGE_W-1:0];
            CSR_COUNT_LIMIT: cfg_in.count_limit = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_limit <= DIST_W'(4000);
         cfg_ff.entry_angle <= '0;
         cfg_ff.exit_angle  <= ANGLE_W'(32768);
         cfg_ff.half_width  <= ANGLE_W'(910);
         cfg_ff.cooldown    <= AGE_W'(3);
         cfg_ff.count_limit <= COUNT_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/zcoc_zone.sv
// ----------------------------------------------------------------------------
// Zone tracker
// Window test, inside flag and cooldown age of one zone.
// ----------------------------------------------------------------------------
module zcoc_zone
   import zcoc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               tick,
   input  logic               sample_ok,
   input  logic               teacher,
   input  logic [ANGLE_W-1:0] angle,
   input  logic [ANGLE_W-1:0] line,
   input  logic [ANGLE_W-1:0] window,
   input  logic [AGE_W-1:0]   cooldown,
   output zone_status_type    status
);

   logic             inside_ff;
   logic             inside_in;
   logic [AGE_W-1:0] age_ff;
   logic [AGE_W-1:0] age_in;
   logic             hit;
   logic             fire;

   assign hit  = in_window(angle, line, window);
   assign fire = sample_ok && hit && !inside_ff && (age_ff >= cooldown);

   always_comb begin
      inside_in = inside_ff;
      age_in    = age_ff;
      if (tick && (age_ff != AGE_MAX)) begin
         age_in = age_ff + AGE_W'(1);
      end
      if (sample_ok) begin
         inside_in = hit;
      end
      if (fire) begin
         age_in = '0;
      end
   end

   always_comb begin
      status.ev_code = EV_NONE;
      status.counted = 1'b0;
      if (fire) begin
         status.ev_code = teacher ? EV_TEACHER : EV_COUNTED;
         status.counted = !teacher;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         age_ff    <= AGE_MAX;
      end else if (step) begin
         inside_ff <= inside_in;
         age_ff    <= age_in;
      end
   end

endmodule

>>> rtl/core/zone_crossing_occupancy_counter.sv
// ----------------------------------------------------------------------------
// Zone crossing occupancy counter
// Counts vehicles crossing entry and exit angle windows of a range scanner.
// ----------------------------------------------------------------------------
// An item moves from the single input registers to the single result registers.
// Throughput: one item per cycle, set by those registers, while results flow.
// Reset clears the count and zone flags, saturates both ages at 255 and loads
// the configuration defaults; no clearing pass is needed.
module zone_crossing_occupancy_counter
   import zcoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [ANGLE_W-1:0]    req_angle_q14,
   input  logic [DIST_W-1:0]     req_distance_q2,
   input  logic [QUAL_W-1:0]     req_quality,
   input  logic                  req_teacher_recent,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_occupancy,
   output logic [1:0]            rsp_entry_event,
   output logic [1:0]            rsp_exit_event,
   output logic                  rsp_sample_accepted,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   csr_type            cfg;
   zone_status_type    entry_status;
   zone_status_type    exit_status;

   logic               in_valid_ff;
   logic               mode_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [QUAL_W-1:0]  qual_ff;
   logic               teacher_ff;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] occ_ff;
   logic [1:0]         entry_ev_ff;
   logic [1:0]         exit_ev_ff;
   logic               accepted_ff;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_mid;
   logic [COUNT_W-1:0] count_in;

   logic               advance;
   logic               tick;
   logic               sample_ok;

   zcoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign tick      = mode_ff;
   assign sample_ok = !mode_ff && (qual_ff != '0) && (dist_ff != '0) &&
                      (dist_ff <= cfg.range_limit);

   zcoc_zone u_entry (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .tick      (tick),
      .sample_ok (sample_ok),
      .teacher   (teacher_ff),
      .angle     (angle_ff),
      .line      (cfg.entry_angle),
      .window    (cfg.half_width),
      .cooldown  (cfg.cooldown),
      .status    (entry_status)
   );

   zcoc_zone u_exit (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .tick      (tick),
      .sample_ok (sample_ok),
      .teacher   (teacher_ff),
      .angle     (angle_ff),
      .line      (cfg.exit_angle),
      .window    (cfg.half_width),
      .cooldown  (cfg.cooldown),
      .status    (exit_status)
   );

   // Entry is applied before exit, so an exit sees the incremented count.
   always_comb begin
      count_mid = count_ff;
      if (entry_status.counted && (count_ff < cfg.count_limit)) begin
         count_mid = count_ff + COUNT_W'(1);
      end
      count_in = count_mid;
      if (exit_status.counted && (count_mid != '0)) begin
         count_in = count_mid - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff    <= req_mode;
         angle_ff   <= req_angle_q14;
         dist_ff    <= req_distance_q2;
         qual_ff    <= req_quality;
         teacher_ff <= req_teacher_recent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            count_ff <= count_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         occ_ff      <= count_in;
         entry_ev_ff <= entry_status.ev_code;
         exit_ev_ff  <= exit_status.ev_code;
         accepted_ff <= sample_ok;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_occupancy       = occ_ff;
   assign rsp_entry_event     = entry_ev_ff;
   assign rsp_exit_event      = exit_ev_ff;
   assign rsp_sample_accepted = accepted_ff;

   a_no_event_without_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !accepted_ff |-> (entry_ev_ff == EV_NONE) && (exit_ev_ff == EV_NONE))
      else $error("event reported for an item that was not an accepted sample");

   a_count_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("count changed without an item advancing");

   a_result_matches_count: assert property (@(posedge clock) disable iff (reset)
      advance |=> (occ_ff == count_ff))
      else $error("reported occupancy differs from the stored count");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule

>>> test/zone_crossing_occupancy_counter_tb.sv
// ----------------------------------------------------------------------------
// Zone crossing occupancy counter testbench
// Drives scanner samples and ticks through the valid/ready request channel
// with bursty timing, stalls the result channel on its own pattern, and checks
// every result against the table or an in-bench occupancy predictor. A short
// directed table comes first, then configuration phases with random crossing
// traffic.
`timescale 1ns / 100ps

module zone_crossing_occupancy_counter_tb;
   import zcoc_pkg::*;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;
   localparam int   ZONE_ENTRY  = 0;
   localparam int   ZONE_EXIT   = 1;
   localparam int   DIST_MAX    = (1 << DIST_W) - 1;
   localparam int   NUM_PHASES  = 8;
   localparam int   DRAIN_CYCLES = 8;
   localparam int   HOLD_CYCLES  = 80;
   localparam int   CYCLE_LIMIT  = 200000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic               mode;
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  distance;
      logic [QUAL_W-1:0]  quality;
      logic               teacher;
   } scan_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] occupancy;
      logic [1:0]         entry_ev;
      logic [1:0]         exit_ev;
      logic               accepted;
   } occupancy_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_mode;
   logic [ANGLE_W-1:0]    req_angle_q14;
   logic [DIST_W-1:0]     req_distance_q2;
   logic [QUAL_W-1:0]     req_quality;
   logic                  req_teacher_recent;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [COUNT_W-1:0]    rsp_occupancy;
   logic [1:0]            rsp_entry_event;
   logic [1:0]            rsp_exit_event;
   logic                  rsp_sample_accepted;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   csr_type               shadow_csr;
   logic [COUNT_W-1:0]    vehicle_count;
   logic                  zone_inside [2];
   logic [AGE_W-1:0]      zone_age [2];

   occupancy_result_type  awaited_readings [$];
   occupancy_result_type  predicted;
   occupancy_result_type  oldest_reading;
   occupancy_result_type  cur_expect;
   bit                    cur_typed;
   scan_item_type         accepted_item;

   scan_item_type         directed_items [$];
   bit                    directed_typed [$];
   occupancy_result_type  directed_expect [$];

   logic [CSR_DATA_W-1:0] csr_value;
   int                    tick_pct;
   int                    entry_pct;
   int                    exit_pct;
   int                    drop_pct;
   int                    phase_items;
   int                    burst_left = 0;
   int                    rsp_hold_requests = 0;
   int                    failures = 0;
   int                    cycle_count = 0;

   zone_crossing_occupancy_counter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_angle_q14       (req_angle_q14),
      .req_distance_q2     (req_distance_q2),
      .req_quality         (req_quality),
      .req_teacher_recent  (req_teacher_recent),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_entry_event     (rsp_entry_event),
      .rsp_exit_event      (rsp_exit_event),
      .rsp_sample_accepted (rsp_sample_accepted),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   function automatic occupancy_result_type predict_occupancy(input scan_item_type it);
      occupancy_result_type r;
      logic [ANGLE_W-1:0]   line;
      logic [ANGLE_W-1:0]   diff;
      logic [1:0]           ev;
      int                   z;
      r = '0;
      if (it.mode == MODE_TICK) begin
         for (z = 0; z < 2; z++) begin
            if (zone_age[z] != AGE_MAX) zone_age[z]++;
         end
      end else if (it.quality != 0 && it.distance != 0 &&
                   it.distance <= shadow_csr.range_limit) begin
         r.accepted = 1'b1;
         for (z = 0; z < 2; z++) begin
            line = (z == ZONE_ENTRY) ? shadow_csr.entry_angle : shadow_csr.exit_angle;
            diff = (it.angle >= line) ? it.angle - line : line - it.angle;
            if (diff >= shadow_csr.half_width) begin
               zone_inside[z] = 1'b0;
            end else if (!zone_inside[z]) begin
               zone_inside[z] = 1'b1;
               if (zone_age[z] >= shadow_csr.cooldown) begin
                  zone_age[z] = '0;
                  if (it.teacher) begin
                     ev = EV_TEACHER;
                  end else begin
                     ev = EV_COUNTED;
                     if (z == ZONE_ENTRY) begin
                        if (vehicle_count < shadow_csr.count_limit) vehicle_count++;
                     end else if (vehicle_count != 0) begin
                        vehicle_count--;
                     end
                  end
                  if (z == ZONE_ENTRY) r.entry_ev = ev;
                  else r.exit_ev = ev;
               end
            end
         end
      end
      r.occupancy = vehicle_count;
      return r;
   endfunction

   function automatic scan_item_type make_scan_item();
      scan_item_type      it;
      int                 roll;
      int                 span;
      logic [ANGLE_W-1:0] line;
      logic [ANGLE_W-1:0] offset;
      roll = $urandom_range(0, 99);
      it.mode = MODE_SAMPLE;
      it.angle = ANGLE_W'($urandom);
      it.distance = DIST_W'($urandom_range(1, (shadow_csr.range_limit == 0) ? 1 :
                                            int'(shadow_csr.range_limit)));
      it.quality = QUAL_W'($urandom_range(1, 255));
      it.teacher = ($urandom_range(0, 4) == 0);
      if (roll < tick_pct) begin
         it.mode = MODE_TICK;
      end else if (roll < tick_pct + entry_pct + exit_pct) begin
         line = (roll < tick_pct + entry_pct) ? shadow_csr.entry_angle :
                                                shadow_csr.exit_angle;
         span = int'(shadow_csr.half_width) + 2;
         offset = ANGLE_W'($urandom_range(0, span));
         it.angle = ($urandom_range(0, 1) == 0) ? line + offset : line - offset;
      end else if (roll < tick_pct + entry_pct + exit_pct + drop_pct) begin
         case ($urandom_range(0, 2))
            0: it.quality = '0;
            1: it.distance = '0;
            default: begin
               if (shadow_csr.range_limit != DIST_W'(DIST_MAX))
                  it.distance = DIST_W'($urandom_range(int'(shadow_csr.range_limit) + 1,
                                                       DIST_MAX));
               else
                  it.quality = '0;
            end
         endcase
      end else begin
         it.distance = DIST_W'($urandom);
         it.quality = QUAL_W'($urandom);
      end
      return it;
   endfunction

   task automatic add_row(input logic mode, input int angle, input int dist_val, input int qual,
                          input logic teacher, input bit typed, input int occ,
                          input logic [1:0] ev_in, input logic [1:0] ev_out,
                          input logic acc);
      scan_item_type        it;
      occupancy_result_type r;
      it.mode = mode;
      it.angle = ANGLE_W'(angle);
      it.distance = DIST_W'(dist_val);
      it.quality = QUAL_W'(qual);
      it.teacher = teacher;
      r.occupancy = COUNT_W'(occ);
      r.entry_ev = ev_in;
      r.exit_ev = ev_out;
      r.accepted = acc;
      directed_items.push_back(it);
      directed_typed.push_back(typed);
      directed_expect.push_back(r);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_RANGE_LIMIT: shadow_csr.range_limit = data[DIST_W-1:0];
         CSR_ENTRY_ANGLE: shadow_csr.entry_angle = data[ANGLE_W-1:0];
         CSR_EXIT_ANGLE:  shadow_csr.exit_angle = data[ANGLE_W-1:0];
         CSR_HALF_WIDTH:  shadow_csr.half_width = data[ANGLE_W-1:0];
         CSR_COOLDOWN:    shadow_csr.cooldown = data[AGE_W-1:0];
         CSR_COUNT_LIMIT: shadow_csr.count_limit = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic offer_item(input scan_item_type it, input bit typed,
                             input occupancy_result_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                      $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_mode = it.mode;
      req_angle_q14 = it.angle;
      req_distance_q2 = it.distance;
      req_quality = it.quality;
      req_teacher_recent = it.teacher;
      cur_typed = typed;
      cur_expect = want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic setup_phase(input int p);
      tick_pct = 15;
      entry_pct = 35;
      exit_pct = 30;
      drop_pct = 10;
      phase_items = 90;
      case (p)
         0: begin
            write_csr(CSR_RANGE_LIMIT, CSR_DATA_W'(DIST_MAX));
            write_csr(CSR_ENTRY_ANGLE, CSR_DATA_W'(0));
            write_csr(CSR_EXIT_ANGLE, CSR_DATA_W'(65535));
            write_csr(CSR_HALF_WIDTH, CSR_DATA_W'(65535));
            write_csr(CSR_COOLDOWN, CSR_DATA_W'(0));
            write_csr(CSR_COUNT_LIMIT, CSR_DATA_W'(1023));
            tick_pct = 10;
            phase_items = 120;
         end
         1: begin
            write_csr(CSR_RANGE_LIMIT, CSR_DATA_W'($urandom_range(1000, DIST_MAX)));
            write_csr(CSR_ENTRY_ANGLE, CSR_DATA_W'(16384));
            write_csr(CSR_EXIT_ANGLE, CSR_DATA_W'(49152));
            write_csr(CSR_HALF_WIDTH, CSR_DATA_W'(2000));
            tick_pct = 5;
            entry_pct = 70;
            exit_pct = 5;
            phase_items = 120;
         end
         2: begin
            write_csr(CSR_COUNT_LIMIT, CSR_DATA_W'(3));
            tick_pct = 10;
            entry_pct = 40;
            phase_items = 80;
         end
         3: begin
            write_csr(CSR_COOLDOWN, CSR_DATA_W'(255));
            write_csr(CSR_COUNT_LIMIT, CSR_DATA_W'(0));
            write_csr(CSR_HALF_WIDTH, CSR_DATA_W'(4000));
            tick_pct = 85;
            entry_pct = 6;
            exit_pct = 6;
            drop_pct = 1;
            phase_items = 330;
         end
         4: begin
            write_csr(CSR_RANGE_LIMIT, CSR_DATA_W'(0));
            write_csr(CSR_HALF_WIDTH, CSR_DATA_W'(0));
            write_csr(CSR_ENTRY_ANGLE, CSR_DATA_W'(65535));
            write_csr(CSR_EXIT_ANGLE, CSR_DATA_W'(0));
            write_csr(CSR_COOLDOWN, CSR_DATA_W'(1));
            phase_items = 30;
         end
         default: begin
            csr_value = CSR_DATA_W'($urandom);
            write_csr(CSR_RANGE_LIMIT, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            write_csr(CSR_ENTRY_ANGLE, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            write_csr(CSR_EXIT_ANGLE, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            csr_value[ANGLE_W-1:0] = ANGLE_W'($urandom_range(0, 6000));
            write_csr(CSR_HALF_WIDTH, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            csr_value[AGE_W-1:0] = AGE_W'($urandom_range(0, 12));
            write_csr(CSR_COOLDOWN, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            write_csr(CSR_COUNT_LIMIT, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            write_csr(CSR_SPARE_6, csr_value);
            csr_value = CSR_DATA_W'($urandom);
            write_csr(CSR_SPARE_7, csr_value);
         end
      endcase
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_readings.size() == 0) begin
               $error("result with no item outstanding: occupancy %0d", rsp_occupancy);
               failures++;
            end else begin
               oldest_reading = awaited_readings.pop_front();
               compare_field("occupancy", 32'(oldest_reading.occupancy), 32'(rsp_occupancy));
               compare_field("entry_event", 32'(oldest_reading.entry_ev),
                             32'(rsp_entry_event));
               compare_field("exit_event", 32'(oldest_reading.exit_ev), 32'(rsp_exit_event));
               compare_field("sample_accepted", 32'(oldest_reading.accepted),
                             32'(rsp_sample_accepted));
            end
         end
         if (req_valid && req_ready) begin
            accepted_item.mode = req_mode;
            accepted_item.angle = req_angle_q14;
            accepted_item.distance = req_distance_q2;
            accepted_item.quality = req_quality;
            accepted_item.teacher = req_teacher_recent;
            predicted = predict_occupancy(accepted_item);
            awaited_readings.push_back(cur_typed ? cur_expect : predicted);
         end
      end
   end

   initial begin : receiver
      int served;
      int hold_left;
      int style;
      int style_left;
      served = 0;
      hold_left = 0;
      style = 0;
      style_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served < rsp_hold_requests) begin
            served++;
            hold_left = HOLD_CYCLES;
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(10, 80);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (style)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 1) == 0);
               2: rsp_ready = (style_left % 3 != 0);
               default: rsp_ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("zone_crossing_occupancy_counter regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      int phase;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_SAMPLE;
      req_angle_q14 = '0;
      req_distance_q2 = '0;
      req_quality = '0;
      req_teacher_recent = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_RANGE_LIMIT;
      csr_data = '0;
      cur_typed = 1'b0;
      cur_expect = '0;
      shadow_csr.range_limit = DIST_W'(4000);
      shadow_csr.entry_angle = '0;
      shadow_csr.exit_angle = ANGLE_W'(32768);
      shadow_csr.half_width = ANGLE_W'(910);
      shadow_csr.cooldown = AGE_W'(3);
      shadow_csr.count_limit = COUNT_W'(64);
      vehicle_count = '0;
      zone_inside[ZONE_ENTRY] = 1'b0;
      zone_inside[ZONE_EXIT] = 1'b0;
      zone_age[ZONE_ENTRY] = AGE_MAX;
      zone_age[ZONE_EXIT] = AGE_MAX;

      //      mode         angle  dist    qual teach typed occ entry       exit        acc
      add_row(MODE_TICK,   0,     0,      0,   0,    1,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 0,     1,      1,   0,    1,    1,  EV_COUNTED, EV_NONE,    1);
      add_row(MODE_SAMPLE, 0,     4000,   255, 0,    1,    1,  EV_NONE,    EV_NONE,    1);
      add_row(MODE_SAMPLE, 0,     4001,   255, 0,    1,    1,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 0,     100,    0,   0,    1,    1,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 0,     0,      9,   0,    1,    1,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 65535, DIST_MAX, 255, 1,  1,    1,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 909,   50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 910,   50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 0,     50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_TICK,   0,     0,      0,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_TICK,   123,   77,     5,   1,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_TICK,   0,     0,      0,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 910,   50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 0,     50,     7,   1,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 32768, 50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 33677, 50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 31859, 50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 1000,  50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_TICK,   0,     0,      0,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_TICK,   0,     0,      0,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_TICK,   0,     0,      0,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 32768, 50,     7,   0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 65535, 1,      255, 0,    0,    0,  EV_NONE,    EV_NONE,    0);
      add_row(MODE_SAMPLE, 16384, 4000,   128, 1,    0,    0,  EV_NONE,    EV_NONE,    0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < directed_items.size(); i++)
         offer_item(directed_items[i], directed_typed[i], directed_expect[i]);
      drain();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         setup_phase(phase);
         if (phase == 1) rsp_hold_requests++;
         for (n = 0; n < phase_items; n++)
            offer_item(make_scan_item(), 1'b0, '0);
         drain();
      end

      if (failures == 0)
         $display("zone_crossing_occupancy_counter regression: pass");
      else
         $display("zone_crossing_occupancy_counter regression: fail");
      $finish;
   end

endmodule

>>> zone_crossing_occupancy_counter.f
rtl/core/zcoc_pkg.sv
rtl/core/zcoc_csr.sv
rtl/core/zcoc_zone.sv
rtl/core/zone_crossing_occupancy_counter.sv
test/zone_crossing_occupancy_counter_tb.sv
